@@ rtl/ffc_pkg.sv @@
`timescale 1ns / 1ps

package ffc_pkg;

   // field widths
   localparam int SAMPLE_W     = 16;
   localparam int COEF_IDX_W   = 4;
   localparam int TAP_CNT_W    = 5;
   localparam int PROD_W       = 2 * SAMPLE_W;
   localparam int FILT_W       = 36;

   // defaults
   localparam int MAX_TAPS_DEF = 16;
   localparam logic [TAP_CNT_W-1:0] TAP_CNT_RST = 5'd16;

   // item kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_COEF   = 1'b1;

   typedef struct packed {
      logic                         kind;
      logic signed [SAMPLE_W-1:0]   sample;
      logic                         last_sample;
      logic        [COEF_IDX_W-1:0] coef_index;
      logic signed [SAMPLE_W-1:0]   coef_value;
   } req_word_type;

   typedef struct packed {
      logic signed [FILT_W-1:0] filtered;
      logic                     end_of_signal;
   } rsp_word_type;

   // sequencer to multiply-accumulate unit
   typedef struct packed {
      logic clear;   // zero the accumulator
      logic issue;   // operands are being read this cycle
   } mac_ctrl_type;

endpackage

@@ rtl/fir_full_convolution.sv @@
`timescale 1ns / 1ps

// channel  ports                              direction  payload
// request  req_valid / req_ready / req_word   in         ffc_pkg::req_word_type
// response rsp_valid / rsp_ready / rsp_word   out        ffc_pkg::rsp_word_type
// csr      csr_wr_en / csr_wr_data            in         tap_count, 5 bits
//
// Coefficient write word: accepted while idle, written to the store, no response.
// Each response word takes one delay-line write, then taps reads of the two
// tap memories into the single multiply-accumulate unit, a drain of its
// product and accumulate stages and the load of the output register. A last
// sample gives taps words, with the request side not ready meanwhile.
// After reset tap_count is 16 and coefficients and delay line read as zero.
// A response word waiting on rsp_ready stalls the sequencer only when the next
// word is finished; the request side is ready again while the last one waits.
module fir_full_convolution #(
   parameter int MAX_TAPS = ffc_pkg::MAX_TAPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  ffc_pkg::req_word_type                req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output ffc_pkg::rsp_word_type                rsp_word,
   input  logic                                 csr_wr_en,
   input  logic [ffc_pkg::TAP_CNT_W-1:0]        csr_wr_data
);

   localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CW = $clog2(MAX_TAPS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_ISSUE,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type                           state_ff, state_in;
   logic [ffc_pkg::TAP_CNT_W-1:0]       tap_ff, tap_in;
   logic [CW-1:0]                       taps_eff;
   logic [CW-1:0]                       taps_ff, taps_in;
   logic [CW-1:0]                       rem_ff, rem_in;
   logic                                last_ff, last_in;
   logic signed [ffc_pkg::SAMPLE_W-1:0] dl_data_ff, dl_data_in;
   logic [AW-1:0]                       head_ff, head_in;
   logic [AW-1:0]                       rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]                       idx_ff, idx_in;
   logic                                drain_ff, drain_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   ffc_pkg::rsp_word_type               rsp_word_ff, rsp_word_in;

   logic [AW-1:0]                       head_dec;
   logic [AW-1:0]                       rd_ptr_inc;
   logic                                req_acc;
   logic                                rsp_load;
   logic                                dl_clear;
   logic                                cf_wr_en;
   ffc_pkg::mac_ctrl_type               mac_ctrl;
   logic signed [ffc_pkg::SAMPLE_W-1:0] dl_rd_data;
   logic signed [ffc_pkg::SAMPLE_W-1:0] cf_rd_data;
   logic signed [ffc_pkg::FILT_W-1:0]   acc;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // tap count register
   assign tap_in = csr_wr_en ? csr_wr_data : tap_ff;

   // active taps: zero means one, clamp to the store depth
   always_comb begin
      if (tap_ff == '0) begin
         taps_eff = CW'(1);
      end else if (int'(tap_ff) > MAX_TAPS) begin
         taps_eff = CW'(MAX_TAPS);
      end else begin
         taps_eff = CW'(tap_ff);
      end
   end

   // coefficient writes go straight to the store
   assign cf_wr_en = req_acc && (req_word.kind == ffc_pkg::KIND_COEF)
                     && (int'(req_word.coef_index) < MAX_TAPS);

   // circular delay line pointers
   assign head_dec   = (head_ff == '0) ? AW'(MAX_TAPS - 1) : head_ff - AW'(1);
   assign rd_ptr_inc = (rd_ptr_ff == AW'(MAX_TAPS - 1)) ? '0 : rd_ptr_ff + AW'(1);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      taps_in      = taps_ff;
      rem_in       = rem_ff;
      last_in      = last_ff;
      dl_data_in   = dl_data_ff;
      head_in      = head_ff;
      rd_ptr_in    = rd_ptr_ff;
      idx_in       = idx_ff;
      drain_in     = drain_ff;
      rsp_load     = 1'b0;
      dl_clear     = 1'b0;
      mac_ctrl     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_word.kind == ffc_pkg::KIND_SAMPLE)) begin
               taps_in    = taps_eff;
               rem_in     = req_word.last_sample ? taps_eff - CW'(1) : '0;
               last_in    = req_word.last_sample;
               dl_data_in = req_word.sample;
               state_in   = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            head_in        = head_dec;
            rd_ptr_in      = head_dec;
            idx_in         = '0;
            mac_ctrl.clear = 1'b1;
            state_in       = ST_ISSUE;
         end
         ST_ISSUE: begin
            mac_ctrl.issue = 1'b1;
            rd_ptr_in      = rd_ptr_inc;
            idx_in         = idx_ff + AW'(1);
            if (CW'(idx_ff) == taps_ff - CW'(1)) begin
               drain_in = 1'b0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               if (rem_ff != '0) begin
                  // tail: shift a zero in and run again
                  rem_in     = rem_ff - CW'(1);
                  dl_data_in = '0;
                  state_in   = ST_SHIFT;
               end else begin
                  dl_clear = last_ff;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_valid_in              = 1'b1;
         rsp_word_in.filtered      = acc;
         rsp_word_in.end_of_signal = last_ff && (rem_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_ff       <= ffc_pkg::TAP_CNT_RST;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         taps_ff      <= CW'(1);
         rem_ff       <= '0;
         last_ff      <= 1'b0;
         idx_ff       <= '0;
         drain_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
         taps_ff      <= taps_in;
         rem_ff       <= rem_in;
         last_ff      <= last_in;
         idx_ff       <= idx_in;
         drain_ff     <= drain_in;
      end
      dl_data_ff  <= dl_data_in;
      rd_ptr_ff   <= rd_ptr_in;
      rsp_word_ff <= rsp_word_in;
   end

   // delay line, newest sample at head
   ffc_tap_mem #(
      .DEPTH (MAX_TAPS),
      .AW    (AW)
   ) u_dl_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (dl_clear),
      .wr_en   (state_ff == ST_SHIFT),
      .wr_addr (head_dec),
      .wr_data (dl_data_ff),
      .rd_en   (mac_ctrl.issue),
      .rd_addr (rd_ptr_ff),
      .rd_data (dl_rd_data)
   );

   // coefficient store
   ffc_tap_mem #(
      .DEPTH (MAX_TAPS),
      .AW    (AW)
   ) u_cf_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (1'b0),
      .wr_en   (cf_wr_en),
      .wr_addr (AW'(req_word.coef_index)),
      .wr_data (req_word.coef_value),
      .rd_en   (mac_ctrl.issue),
      .rd_addr (idx_ff),
      .rd_data (cf_rd_data)
   );

   ffc_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (mac_ctrl),
      .sample_op (dl_rd_data),
      .coef_op   (cf_rd_data),
      .acc       (acc)
   );

   // tap index stays inside the active taps
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> (CW'(idx_ff) < taps_ff))
      else $error("tap index beyond active taps");

   // tail counter never reaches the tap count
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (rem_ff < taps_ff))
      else $error("tail count out of range");

   // latched tap count within 1..MAX_TAPS
   a_taps_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> ((taps_ff != '0) && (int'(taps_ff) <= MAX_TAPS)))
      else $error("active tap count out of range");

   // a finished sum waits while the output register is still held
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && rsp_valid_ff && !rsp_ready)
      |=> ((state_ff == ST_DONE) && rsp_valid_ff))
      else $error("finished sum overwrote a waiting word");

endmodule

@@ rtl/ffc_tap_mem.sv @@
`timescale 1ns / 1ps

// Tap memory: one write port, one registered read port.
// Entries never written since reset or the last clear read as zero.
module ffc_tap_mem #(
   parameter int DEPTH = ffc_pkg::MAX_TAPS_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 clear,
   input  logic                                 wr_en,
   input  logic [AW-1:0]                        wr_addr,
   input  logic signed [ffc_pkg::SAMPLE_W-1:0]  wr_data,
   input  logic                                 rd_en,
   input  logic [AW-1:0]                        rd_addr,
   output logic signed [ffc_pkg::SAMPLE_W-1:0]  rd_data
);

   logic signed [ffc_pkg::SAMPLE_W-1:0] mem [DEPTH];
   logic        [DEPTH-1:0]             vld_ff;
   logic        [DEPTH-1:0]             vld_in;
   logic signed [ffc_pkg::SAMPLE_W-1:0] rd_data_ff;

   // valid bits: cleared at once, set on write
   always_comb begin
      vld_in = vld_ff;
      if (clear) begin
         vld_in = '0;
      end else if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= vld_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/ffc_mac.sv @@
`timescale 1ns / 1ps

// Shared multiply-accumulate: one product per cycle, registered,
// then added into a wrapping accumulator.
module ffc_mac (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ffc_pkg::mac_ctrl_type                ctrl,
   input  logic signed [ffc_pkg::SAMPLE_W-1:0]  sample_op,
   input  logic signed [ffc_pkg::SAMPLE_W-1:0]  coef_op,
   output logic signed [ffc_pkg::FILT_W-1:0]    acc
);

   logic                               op_vld_ff;
   logic                               prod_vld_ff;
   logic signed [ffc_pkg::PROD_W-1:0]  prod_ff;
   logic signed [ffc_pkg::FILT_W-1:0]  acc_ff;
   logic signed [ffc_pkg::FILT_W-1:0]  acc_in;

   // operands arrive in the cycle after issue (registered memory read)
   always_ff @(posedge clock) begin
      if (reset) begin
         op_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         op_vld_ff   <= ctrl.issue;
         prod_vld_ff <= op_vld_ff;
      end
   end

   // product stage
   always_ff @(posedge clock) begin
      if (op_vld_ff) begin
         prod_ff <= sample_op * coef_op;
      end
   end

   // accumulate, low bits kept
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ffc_pkg::FILT_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule
